[hw/rtl/qbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package qbs_pkg;

    localparam int DW_DEF = 32;
    localparam int FB_DEF = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_KNOT0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KNOT1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KNOT2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KNOT3 = 2'd3;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // span codes
    typedef logic [1:0] t_span;
    localparam t_span SPAN_NONE = 2'd0;
    localparam t_span SPAN_1    = 2'd1;
    localparam t_span SPAN_2    = 2'd2;
    localparam t_span SPAN_3    = 2'd3;

    typedef struct packed {
        t_span span;
        logic  e32;   // knot_3 == knot_2
        logic  e31;   // knot_3 == knot_1
    } t_cls;

    // width of numerators and denominators ahead of the divider
    function automatic int num_width(input int dw, input int fb);
        return 3 * dw + fb + 6;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/qbs_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface qbs_in_if #(parameter int DATA_WIDTH = 32);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] sample_point;
    modport source (output valid, output sample_point, input ready);
    modport sink (input valid, input sample_point, output ready);
endinterface

interface qbs_out_if #(parameter int DATA_WIDTH = 32);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] basis_value;
    logic [DATA_WIDTH-1:0] basis_slope;
    logic                  saturated;
    modport source (output valid, output basis_value, output basis_slope, output saturated,
                    input ready);
    modport sink (input valid, input basis_value, input basis_slope, input saturated,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/qbs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module qbs_front import qbs_pkg::*; #(
    parameter int DATA_WIDTH = DW_DEF,
    parameter int FRAC_BITS  = FB_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [DATA_WIDTH-1:0]        i_cfg_data,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [DATA_WIDTH-1:0]        i_sample_point,
    output logic                              o_valid,
    input  wire logic                         i_pop,
    output t_cls                              o_cls,
    output logic signed [DATA_WIDTH:0]        o_a,
    output logic signed [DATA_WIDTH:0]        o_b,
    output logic signed [DATA_WIDTH:0]        o_c,
    output logic signed [DATA_WIDTH:0]        o_d,
    output logic signed [DATA_WIDTH:0]        o_d10,
    output logic signed [DATA_WIDTH:0]        o_d20,
    output logic signed [DATA_WIDTH:0]        o_d21,
    output logic signed [DATA_WIDTH:0]        o_d31,
    output logic signed [DATA_WIDTH:0]        o_d32,
    output logic signed [DATA_WIDTH-1:0]      o_k3
);
    localparam int D1 = DATA_WIDTH + 1;
    localparam int CW = $bits(t_cls);
    localparam int EW = CW + 9 * D1 + DATA_WIDTH;

    logic signed [DATA_WIDTH-1:0] r_k0, r_k1, r_k2, r_k3;
    logic [EW-1:0]                r_q [QDEPTH];
    logic [QPTR_W-1:0]            r_wp, r_rp;
    logic [QPTR_W:0]              r_count;

    logic signed [DATA_WIDTH-1:0] t;
    logic signed [D1-1:0]         a, b, c, d, d10, d20, d21, d31, d32;
    t_cls                         cls;
    logic                         push;
    logic [EW-1:0]                head;

    // knot registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k0 <= '0;
            r_k1 <= DATA_WIDTH'(64'd1 << FRAC_BITS);
            r_k2 <= DATA_WIDTH'(64'd2 << FRAC_BITS);
            r_k3 <= DATA_WIDTH'(64'd3 << FRAC_BITS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KNOT0: r_k0 <= i_cfg_data;
                REG_KNOT1: r_k1 <= i_cfg_data;
                REG_KNOT2: r_k2 <= i_cfg_data;
                REG_KNOT3: r_k3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classify and take differences
    always_comb begin
        t   = i_sample_point;
        a   = D1'(t) - D1'(r_k0);
        b   = D1'(t) - D1'(r_k1);
        c   = D1'(r_k2) - D1'(t);
        d   = D1'(r_k3) - D1'(t);
        d10 = D1'(r_k1) - D1'(r_k0);
        d20 = D1'(r_k2) - D1'(r_k0);
        d21 = D1'(r_k2) - D1'(r_k1);
        d31 = D1'(r_k3) - D1'(r_k1);
        d32 = D1'(r_k3) - D1'(r_k2);
        cls.e32 = (r_k3 == r_k2);
        cls.e31 = (r_k3 == r_k1);
        if (t >= r_k0 && t < r_k1)       cls.span = SPAN_1;
        else if (t >= r_k1 && t < r_k2)  cls.span = SPAN_2;
        else if (t >= r_k2 && t <= r_k3) cls.span = SPAN_3;
        else                             cls.span = SPAN_NONE;
    end

    assign o_ready = (r_count != (QPTR_W+1)'(QDEPTH));
    assign push    = i_valid && o_ready;
    assign o_valid = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= {cls, a, b, c, d, d10, d20, d21, d31, d32, t};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_count <= r_count + (QPTR_W+1)'(push) - (QPTR_W+1)'(i_pop);
        end
    end

    assign head = r_q[r_rp];
    assign {o_cls, o_a, o_b, o_c, o_d, o_d10, o_d20, o_d21, o_d31, o_d32} =
        head[EW-1:DATA_WIDTH];
    // the k3 slot of each entry holds t; rebuild k3 from d = k3 - t
    assign o_k3 = DATA_WIDTH'(o_d + D1'($signed(head[DATA_WIDTH-1:0])));

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0) else $error("queue popped while empty");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 r_count == $past(r_count) + (QPTR_W+1)'($past(push))
                       - (QPTR_W+1)'($past(i_pop))) else $error("queue count mismatch");

endmodule
`default_nettype wire

[hw/rtl/qbs_arith.sv]
`timescale 1ns / 1ps
`default_nettype none
module qbs_arith import qbs_pkg::*; #(
    parameter int DATA_WIDTH = DW_DEF,
    parameter int FRAC_BITS  = FB_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire t_cls                          i_cls,
    input  wire logic signed [DATA_WIDTH:0]    i_a,
    input  wire logic signed [DATA_WIDTH:0]    i_b,
    input  wire logic signed [DATA_WIDTH:0]    i_c,
    input  wire logic signed [DATA_WIDTH:0]    i_d,
    input  wire logic signed [DATA_WIDTH:0]    i_d10,
    input  wire logic signed [DATA_WIDTH:0]    i_d20,
    input  wire logic signed [DATA_WIDTH:0]    i_d21,
    input  wire logic signed [DATA_WIDTH:0]    i_d31,
    input  wire logic signed [DATA_WIDTH:0]    i_d32,
    input  wire logic signed [DATA_WIDTH-1:0]  i_k3,
    output logic                               o_valid,
    output logic [num_width(DATA_WIDTH, FRAC_BITS)-1:0] o_num_v,
    output logic [num_width(DATA_WIDTH, FRAC_BITS)-1:0] o_num_s,
    output logic [num_width(DATA_WIDTH, FRAC_BITS)-1:0] o_den,
    output logic                               o_neg_v,
    output logic                               o_neg_s,
    output logic                               o_zden
);
    localparam int D1 = DATA_WIDTH + 1;
    localparam int SW = num_width(DATA_WIDTH, FRAC_BITS);

    // stage 1: first products
    logic                  r1_vld;
    t_cls                  r1_cls;
    logic signed [D1-1:0]  r1_a, r1_d, r1_d20, r1_d31;
    logic signed [DATA_WIDTH-1:0] r1_k3;
    logic signed [2*D1-1:0] r1_pden, r1_pv, r1_pv2;
    logic signed [2*D1:0]   r1_ps1, r1_ps2;
    logic signed [D1-1:0]   mx_den, my_den, mx_v, my_v;
    logic signed [D1:0]     ca, db;

    always_comb begin
        mx_den = (i_cls.span == SPAN_3) ? i_d31 : i_d20;
        case (i_cls.span)
            SPAN_1:  my_den = i_d10;
            SPAN_3:  my_den = i_d32;
            default: my_den = i_d21;
        endcase
        mx_v = (i_cls.span == SPAN_3) ? i_d : i_a;
        case (i_cls.span)
            SPAN_2:  my_v = i_c;
            SPAN_3:  my_v = i_d;
            default: my_v = i_a;
        endcase
        ca = (D1+1)'(i_c) - (D1+1)'(i_a);
        db = (D1+1)'(i_d) - (D1+1)'(i_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (i_en) r1_vld <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cls  <= i_cls;
            r1_a    <= i_a;
            r1_d    <= i_d;
            r1_d20  <= i_d20;
            r1_d31  <= i_d31;
            r1_k3   <= i_k3;
            r1_pden <= mx_den * my_den;
            r1_pv   <= mx_v * my_v;
            r1_pv2  <= i_d * i_b;
            r1_ps1  <= ca * i_d31;
            r1_ps2  <= db * i_d20;
        end
    end

    // stage 2a: wide first product times the third factor as two narrow partial products
    // (unsigned low half, signed high half), summed in the next stage
    logic                   rp_vld;
    t_cls                   rp_cls;
    logic signed [D1-1:0]   rp_a, rp_d;
    logic signed [DATA_WIDTH-1:0] rp_k3;
    logic signed [2*D1-1:0] rp_pden, rp_pv;
    logic signed [2*D1:0]   rp_ps1, rp_ps2;
    logic signed [2*D1:0]   rp_den_lo, rp_v1_lo, rp_v2_lo;
    logic signed [2*D1-1:0] rp_den_hi, rp_v1_hi, rp_v2_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rp_vld <= 1'b0;
        else if (i_en) rp_vld <= r1_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rp_cls    <= r1_cls;
            rp_a      <= r1_a;
            rp_d      <= r1_d;
            rp_k3     <= r1_k3;
            rp_pden   <= r1_pden;
            rp_pv     <= r1_pv;
            rp_ps1    <= r1_ps1;
            rp_ps2    <= r1_ps2;
            rp_den_lo <= $signed({1'b0, r1_pden[D1-1:0]}) * r1_d31;
            rp_den_hi <= $signed(r1_pden[2*D1-1:D1]) * r1_d31;
            rp_v1_lo  <= $signed({1'b0, r1_pv[D1-1:0]}) * r1_d31;
            rp_v1_hi  <= $signed(r1_pv[2*D1-1:D1]) * r1_d31;
            rp_v2_lo  <= $signed({1'b0, r1_pv2[D1-1:0]}) * r1_d20;
            rp_v2_hi  <= $signed(r1_pv2[2*D1-1:D1]) * r1_d20;
        end
    end

    // stage 2: partial product sums, span select, scaling
    logic                  r2_vld;
    logic signed [SW-1:0]  r2_vn, r2_sn, r2_den;
    logic signed [3*D1-1:0] den2;
    logic signed [3*D1:0]   vsum;
    logic signed [2*D1+1:0] ssum;
    logic signed [SW-1:0]  vn, sn, den, k3x2;

    always_comb begin
        den2 = ((3*D1)'(rp_den_hi) <<< D1) + (3*D1)'(rp_den_lo);
        vsum = ((3*D1+1)'(rp_v1_hi) <<< D1) + (3*D1+1)'(rp_v1_lo)
             + ((3*D1+1)'(rp_v2_hi) <<< D1) + (3*D1+1)'(rp_v2_lo);
        ssum = (2*D1+2)'(rp_ps1) + (2*D1+2)'(rp_ps2);
        k3x2 = SW'(rp_k3) <<< 1;
        vn   = '0;
        sn   = '0;
        den  = SW'(1);
        case (rp_cls.span)
            SPAN_1: begin
                den = SW'(rp_pden);
                vn  = SW'(rp_pv) <<< FRAC_BITS;
                sn  = SW'(rp_a) <<< (2 * FRAC_BITS + 1);
            end
            SPAN_2: begin
                den = SW'(den2);
                vn  = SW'(vsum) <<< FRAC_BITS;
                sn  = SW'(ssum) <<< (2 * FRAC_BITS);
            end
            SPAN_3: begin
                if (rp_cls.e32) begin
                    // double or triple end knot: fixed results through a unit divide
                    den = SW'(1);
                    vn  = rp_cls.e31 ? SW'(rp_k3) : '0;
                    sn  = rp_cls.e31 ? k3x2 : -k3x2;
                end else begin
                    den = SW'(rp_pden);
                    vn  = SW'(rp_pv) <<< FRAC_BITS;
                    sn  = -(SW'(rp_d) <<< (2 * FRAC_BITS + 1));
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else if (i_en) r2_vld <= rp_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_vn  <= vn;
            r2_sn  <= sn;
            r2_den <= den;
        end
    end

    // stage 3: sign and magnitude
    logic                 r3_vld;
    logic [SW-1:0]        r3_nv, r3_ns, r3_den;
    logic                 r3_negv, r3_negs, r3_zd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else if (i_en) r3_vld <= r2_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_nv   <= r2_vn[SW-1] ? -r2_vn : r2_vn;
            r3_ns   <= r2_sn[SW-1] ? -r2_sn : r2_sn;
            r3_den  <= r2_den[SW-1] ? -r2_den : r2_den;
            r3_negv <= r2_vn[SW-1] ^ r2_den[SW-1];
            r3_negs <= r2_sn[SW-1] ^ r2_den[SW-1];
            r3_zd   <= (r2_den == '0);
        end
    end

    assign o_valid = r3_vld;
    assign o_num_v = r3_nv;
    assign o_num_s = r3_ns;
    assign o_den   = r3_den;
    assign o_neg_v = r3_negv;
    assign o_neg_s = r3_negs;
    assign o_zden  = r3_zd;

endmodule
`default_nettype wire

[hw/rtl/qbs_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module qbs_div import qbs_pkg::*; #(
    parameter int DATA_WIDTH = DW_DEF,
    parameter int FRAC_BITS  = FB_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [num_width(DATA_WIDTH, FRAC_BITS)-1:0] i_num_v,
    input  wire logic [num_width(DATA_WIDTH, FRAC_BITS)-1:0] i_num_s,
    input  wire logic [num_width(DATA_WIDTH, FRAC_BITS)-1:0] i_den,
    input  wire logic                          i_neg_v,
    input  wire logic                          i_neg_s,
    input  wire logic                          i_zden,
    output logic                               o_valid,
    output logic [DATA_WIDTH-1:0]              o_value,
    output logic [DATA_WIDTH-1:0]              o_slope,
    output logic                               o_sat
);
    localparam int SW = num_width(DATA_WIDTH, FRAC_BITS);
    localparam int XW = SW + DATA_WIDTH;

    logic                  r_vld [DATA_WIDTH+1];
    logic [SW-1:0]         r_rv  [DATA_WIDTH+1];
    logic [SW-1:0]         r_rs  [DATA_WIDTH+1];
    logic [SW-1:0]         r_den [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] r_qv  [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] r_qs  [DATA_WIDTH+1];
    logic                  r_ovv [DATA_WIDTH+1];
    logic                  r_ovs [DATA_WIDTH+1];
    logic                  r_nv  [DATA_WIDTH+1];
    logic                  r_ns  [DATA_WIDTH+1];
    logic                  r_zd  [DATA_WIDTH+1];

    // overflow precheck: quotient would need more than DATA_WIDTH bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld[0] <= 1'b0;
        else if (i_en) r_vld[0] <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rv[0]  <= i_num_v;
            r_rs[0]  <= i_num_s;
            r_den[0] <= i_den;
            r_qv[0]  <= '0;
            r_qs[0]  <= '0;
            r_ovv[0] <= {{DATA_WIDTH{1'b0}}, i_num_v} >= {i_den, {DATA_WIDTH{1'b0}}};
            r_ovs[0] <= {{DATA_WIDTH{1'b0}}, i_num_s} >= {i_den, {DATA_WIDTH{1'b0}}};
            r_nv[0]  <= i_neg_v;
            r_ns[0]  <= i_neg_s;
            r_zd[0]  <= i_zden;
        end
    end

    // restoring division, one quotient bit per stage, MSB first
    for (genvar s = 1; s <= DATA_WIDTH; s++) begin : g_stage
        localparam int BIT = DATA_WIDTH - s;
        logic [XW-1:0] dsh;
        logic          take_v, take_s;

        assign dsh    = {{DATA_WIDTH{1'b0}}, r_den[s-1]} << BIT;
        assign take_v = {{DATA_WIDTH{1'b0}}, r_rv[s-1]} >= dsh;
        assign take_s = {{DATA_WIDTH{1'b0}}, r_rs[s-1]} >= dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[s] <= 1'b0;
            else if (i_en) r_vld[s] <= r_vld[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rv[s]  <= take_v ? r_rv[s-1] - dsh[SW-1:0] : r_rv[s-1];
                r_rs[s]  <= take_s ? r_rs[s-1] - dsh[SW-1:0] : r_rs[s-1];
                r_qv[s]  <= r_qv[s-1] | (DATA_WIDTH'(take_v) << BIT);
                r_qs[s]  <= r_qs[s-1] | (DATA_WIDTH'(take_s) << BIT);
                r_den[s] <= r_den[s-1];
                r_ovv[s] <= r_ovv[s-1];
                r_ovs[s] <= r_ovs[s-1];
                r_nv[s]  <= r_nv[s-1];
                r_ns[s]  <= r_ns[s-1];
                r_zd[s]  <= r_zd[s-1];
            end
        end
    end

    // apply sign and clip to the signed range; MSB of result is the clip flag
    function automatic logic [DATA_WIDTH:0] sat_q(input logic [DATA_WIDTH-1:0] q,
                                                  input logic ovf, input logic neg);
        logic [DATA_WIDTH-1:0] maxv;
        logic [DATA_WIDTH-1:0] minv;
        maxv = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        minv = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        if (!neg) begin
            if (ovf || q[DATA_WIDTH-1]) return {1'b1, maxv};
            return {1'b0, q};
        end
        if (ovf || q > minv) return {1'b1, minv};
        return {1'b0, -q};
    endfunction

    logic [DATA_WIDTH:0] res_v, res_s;
    logic                r_out_vld;
    logic [DATA_WIDTH-1:0] r_out_val, r_out_slp;
    logic                r_out_sat;

    assign res_v = sat_q(r_qv[DATA_WIDTH], r_ovv[DATA_WIDTH], r_nv[DATA_WIDTH]);
    assign res_s = sat_q(r_qs[DATA_WIDTH], r_ovs[DATA_WIDTH], r_ns[DATA_WIDTH]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else if (i_en) r_out_vld <= r_vld[DATA_WIDTH];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zd[DATA_WIDTH]) begin
                r_out_val <= '0;
                r_out_slp <= '0;
                r_out_sat <= 1'b1;
            end else begin
                r_out_val <= res_v[DATA_WIDTH-1:0];
                r_out_slp <= res_s[DATA_WIDTH-1:0];
                r_out_sat <= res_v[DATA_WIDTH] | res_s[DATA_WIDTH];
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_value = r_out_val;
    assign o_slope = r_out_slp;
    assign o_sat   = r_out_sat;

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_vld[DATA_WIDTH] |=> r_out_vld) else $error("result dropped");
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_vld[DATA_WIDTH] && r_zd[DATA_WIDTH] |=>
        r_out_sat && r_out_val == '0 && r_out_slp == '0) else $error("zero divisor result");

endmodule
`default_nettype wire

[hw/rtl/quadratic_bspline_basis_eval.sv]
// Quadratic B-spline basis evaluator, one basis over four knots, Q16.16 by default.
// Throughput: one transaction per cycle while o_out.ready does not stall the output.
// A 4-entry queue splits the classifier from the arithmetic; the pipeline stalls whole.
// Reset (synchronous, active low) empties the queue and pipeline, knots go to 0,1,2,3.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_bspline_basis_eval import qbs_pkg::*; #(
    parameter int DATA_WIDTH = DW_DEF,
    parameter int FRAC_BITS  = FB_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [DATA_WIDTH-1:0] i_cfg_data,
    qbs_in_if.sink                     i_in,
    qbs_out_if.source                  o_out
);
    localparam int SW = num_width(DATA_WIDTH, FRAC_BITS);

    // front -> queue -> back
    logic                         q_valid, pop, en;
    t_cls                         q_cls;
    logic signed [DATA_WIDTH:0]   q_a, q_b, q_c, q_d, q_d10, q_d20, q_d21, q_d31, q_d32;
    logic signed [DATA_WIDTH-1:0] q_k3;

    // arithmetic -> divider
    logic          ar_valid, ar_negv, ar_negs, ar_zd;
    logic [SW-1:0] ar_nv, ar_ns, ar_den;

    logic                  dv_valid, dv_sat;
    logic [DATA_WIDTH-1:0] dv_val, dv_slp;

    // whole back end moves unless a finished result is waiting
    assign en  = !dv_valid || o_out.ready;
    assign pop = en && q_valid;

    qbs_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_in.valid),
        .o_ready        (i_in.ready),
        .i_sample_point (i_in.sample_point),
        .o_valid        (q_valid),
        .i_pop          (pop),
        .o_cls          (q_cls),
        .o_a            (q_a),
        .o_b            (q_b),
        .o_c            (q_c),
        .o_d            (q_d),
        .o_d10          (q_d10),
        .o_d20          (q_d20),
        .o_d21          (q_d21),
        .o_d31          (q_d31),
        .o_d32          (q_d32),
        .o_k3           (q_k3)
    );

    // products, span select, sign/magnitude
    qbs_arith #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid),
        .i_cls   (q_cls),
        .i_a     (q_a),
        .i_b     (q_b),
        .i_c     (q_c),
        .i_d     (q_d),
        .i_d10   (q_d10),
        .i_d20   (q_d20),
        .i_d21   (q_d21),
        .i_d31   (q_d31),
        .i_d32   (q_d32),
        .i_k3    (q_k3),
        .o_valid (ar_valid),
        .o_num_v (ar_nv),
        .o_num_s (ar_ns),
        .o_den   (ar_den),
        .o_neg_v (ar_negv),
        .o_neg_s (ar_negs),
        .o_zden  (ar_zd)
    );

    // truncating divide, saturation, output register
    qbs_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ar_valid),
        .i_num_v (ar_nv),
        .i_num_s (ar_ns),
        .i_den   (ar_den),
        .i_neg_v (ar_negv),
        .i_neg_s (ar_negs),
        .i_zden  (ar_zd),
        .o_valid (dv_valid),
        .o_value (dv_val),
        .o_slope (dv_slp),
        .o_sat   (dv_sat)
    );

    assign o_out.valid       = dv_valid;
    assign o_out.basis_value = dv_val;
    assign o_out.basis_slope = dv_slp;
    assign o_out.saturated   = dv_sat;

endmodule
`default_nettype wire
